>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IHFP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IHFP_ASSERT_IMPL(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define IHFP_ASSERT(lbl, clk, rst, prop, msg)
`define IHFP_ASSERT_IMPL(lbl, clk, rst, pre, post, msg)
`endif
`endif

>>> src/ihfp_pkg.sv
// ----------------------------------------------------------------------------
// ihfp_pkg
// Shared widths and constants of the fiber point datapath.
// ----------------------------------------------------------------------------
package ihfp_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int PHASE_BITS = 16;
   localparam int IO_W       = 18;
   localparam int THR_W      = 17;
   localparam int ONE        = 1 << FRAC_BITS;

   // square root cells: one result bit per cell
   localparam int SQ_IN_W  = 2 * FRAC_BITS + 5;
   localparam int SQ_ACC_W = SQ_IN_W + 1;
   localparam int SQ_CELLS = (SQ_IN_W + 1) / 2;
   localparam int ROOT_W   = SQ_CELLS;

   // divider cells: one quotient bit per cell
   localparam int DIV_W     = 2 * FRAC_BITS + 3;
   localparam int DEN_W     = FRAC_BITS + 2;
   localparam int QUO_W     = FRAC_BITS + 2;
   localparam int DIV_CELLS = QUO_W;
   localparam int DIV_SH_W  = $clog2(QUO_W);

   // series cells work in unsigned Q30
   localparam int Q_W       = 30;
   localparam int TRIG_W    = Q_W + 1;
   localparam int TERM_LAT  = 4;
   localparam int SIN_TERMS = 6;
   localparam int COS_TERMS = 7;
   localparam logic [TRIG_W-1:0] Q30_ONE   = TRIG_W'(1) << Q_W;
   localparam logic [TRIG_W-1:0] Q30_HALF  = TRIG_W'(1) << (Q_W - 1);
   localparam logic [TRIG_W-1:0] HALF_PI_Q30 = TRIG_W'(1686629713);

   typedef logic [7:0]  div_type;
   typedef logic [31:0] recip_type;

   localparam div_type SIN_DIVS [SIN_TERMS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
   localparam div_type COS_DIVS [COS_TERMS] =
      '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

   localparam recip_type SIN_RECIP [SIN_TERMS] = '{
      32'(64'h1_0000_0000 / 64'd156), 32'(64'h1_0000_0000 / 64'd110),
      32'(64'h1_0000_0000 / 64'd72),  32'(64'h1_0000_0000 / 64'd42),
      32'(64'h1_0000_0000 / 64'd20),  32'(64'h1_0000_0000 / 64'd6)};
   localparam recip_type COS_RECIP [COS_TERMS] = '{
      32'(64'h1_0000_0000 / 64'd182), 32'(64'h1_0000_0000 / 64'd132),
      32'(64'h1_0000_0000 / 64'd90),  32'(64'h1_0000_0000 / 64'd56),
      32'(64'h1_0000_0000 / 64'd30),  32'(64'h1_0000_0000 / 64'd12),
      32'(64'h1_0000_0000 / 64'd2)};

endpackage

>>> src/ihfp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ihfp_sqrt_cell
// One bit of a pipelined digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module ihfp_sqrt_cell (
   input  logic                           clock,
   input  logic [ihfp_pkg::SQ_IN_W-1:0]   rad_i,
   input  logic [ihfp_pkg::SQ_ACC_W-1:0]  root_i,
   input  logic [ihfp_pkg::SQ_ACC_W-1:0]  bit_i,
   output logic [ihfp_pkg::SQ_IN_W-1:0]   rad_o,
   output logic [ihfp_pkg::SQ_ACC_W-1:0]  root_o
);
   import ihfp_pkg::*;

   logic [SQ_ACC_W-1:0] trial;
   logic                fit;
   logic [SQ_IN_W-1:0]  rad_in, rad_ff;
   logic [SQ_ACC_W-1:0] root_in, root_ff;

   // try the next bit and subtract when it fits
   always_comb begin
      trial   = root_i + bit_i;
      fit     = {1'b0, rad_i} >= trial;
      rad_in  = fit ? rad_i - trial[SQ_IN_W-1:0] : rad_i;
      root_in = fit ? (root_i >> 1) + bit_i : root_i >> 1;
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      root_ff <= root_in;
   end

   assign rad_o  = rad_ff;
   assign root_o = root_ff;
endmodule

>>> src/ihfp_div_cell.sv
// ----------------------------------------------------------------------------
// ihfp_div_cell
// One quotient bit of a pipelined restoring divider.
// ----------------------------------------------------------------------------
module ihfp_div_cell (
   input  logic                           clock,
   input  logic [ihfp_pkg::DIV_W-1:0]     rem_i,
   input  logic [ihfp_pkg::DEN_W-1:0]     den_i,
   input  logic [ihfp_pkg::QUO_W-1:0]     quo_i,
   input  logic [ihfp_pkg::DIV_SH_W-1:0]  shift_i,
   output logic [ihfp_pkg::DIV_W-1:0]     rem_o,
   output logic [ihfp_pkg::DEN_W-1:0]     den_o,
   output logic [ihfp_pkg::QUO_W-1:0]     quo_o
);
   import ihfp_pkg::*;

   logic [DIV_W-1:0] sub;
   logic             fit;
   logic [DIV_W-1:0] rem_in, rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [QUO_W-1:0] quo_in, quo_ff;

   // compare against the shifted divisor and shift in the quotient bit
   always_comb begin
      sub    = DIV_W'(den_i) << shift_i;
      fit    = rem_i >= sub;
      rem_in = fit ? rem_i - sub : rem_i;
      quo_in = {quo_i[QUO_W-2:0], fit};
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_i;
      quo_ff <= quo_in;
   end

   assign rem_o = rem_ff;
   assign den_o = den_ff;
   assign quo_o = quo_ff;
endmodule

>>> src/ihfp_term_cell.sv
// ----------------------------------------------------------------------------
// ihfp_term_cell
// One Horner step of the sine or cosine series: t' = 1 - x2*t/k in Q30.
// ----------------------------------------------------------------------------
module ihfp_term_cell (
   input  logic                         clock,
   input  logic [ihfp_pkg::Q_W-1:0]     x2_i,
   input  logic [ihfp_pkg::TRIG_W-1:0]  t_i,
   input  ihfp_pkg::div_type            div_k_i,
   input  ihfp_pkg::recip_type          recip_i,
   output logic [ihfp_pkg::Q_W-1:0]     x2_o,
   output logic [ihfp_pkg::TRIG_W-1:0]  t_o
);
   import ihfp_pkg::*;

   localparam int P_W  = Q_W + TRIG_W;
   localparam int PR_W = TRIG_W + 32;

   logic [Q_W-1:0]    x2_a_ff, x2_b_ff, x2_c_ff, x2_d_ff;
   logic [P_W-1:0]    p_in, p_ff;
   logic [TRIG_W-1:0] m_in, m_ff, m_c_ff;
   logic [PR_W-1:0]   pr_in, pr_ff;
   logic [TRIG_W-1:0] q0, rem, quo, t_in, t_ff;

   // product, rounding, reciprocal product
   assign p_in  = P_W'(x2_i) * P_W'(t_i);
   assign m_in  = TRIG_W'((p_ff + P_W'(Q30_HALF)) >> Q_W);
   assign pr_in = PR_W'(m_ff) * PR_W'(recip_i);

   // correct the estimate by one step and close the Horner step
   always_comb begin
      q0   = TRIG_W'(pr_ff >> 32);
      rem  = m_c_ff - TRIG_W'(q0 * TRIG_W'(div_k_i));
      quo  = (rem >= TRIG_W'(div_k_i)) ? q0 + TRIG_W'(1) : q0;
      t_in = Q30_ONE - quo;
   end

   always_ff @(posedge clock) begin
      x2_a_ff <= x2_i;
      x2_b_ff <= x2_a_ff;
      x2_c_ff <= x2_b_ff;
      x2_d_ff <= x2_c_ff;
      p_ff    <= p_in;
      m_ff    <= m_in;
      pr_ff   <= pr_in;
      m_c_ff  <= m_ff;
      t_ff    <= t_in;
   end

   assign x2_o = x2_d_ff;
   assign t_o  = t_ff;
endmodule

>>> src/inverse_hopf_fiber_point.sv
// ----------------------------------------------------------------------------
// inverse_hopf_fiber_point
// Lifts a point of the 2-sphere and a fiber phase to a point of the 3-sphere.
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  request   start, busy, req_*            taken when start and not busy
//  response  rsp_strobe, rsp_*             one cycle, cannot be held off
//  control   csr_write_en, csr_write_data  written at once, no read-back
//
// One word enters every cycle while busy is low.
// The latency is set by the divider cell chain that follows the square root
// cells; the series cells for sine and cosine run alongside and are delayed.
// Synchronous reset clears the valid line and the threshold and sets busy, which
// stays high into the cycle after reset. The receiver cannot stall the response.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module inverse_hopf_fiber_point (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [ihfp_pkg::IO_W-1:0]    req_sphere_x,
   input  logic signed [ihfp_pkg::IO_W-1:0]    req_sphere_y,
   input  logic signed [ihfp_pkg::IO_W-1:0]    req_sphere_z,
   input  logic [15:0]                         req_fiber_phase,
   output logic                                rsp_strobe,
   output logic signed [ihfp_pkg::IO_W-1:0]    rsp_out_w,
   output logic signed [ihfp_pkg::IO_W-1:0]    rsp_out_x,
   output logic signed [ihfp_pkg::IO_W-1:0]    rsp_out_y,
   output logic signed [ihfp_pkg::IO_W-1:0]    rsp_out_z,
   output logic                                rsp_at_pole,
   input  logic                                csr_write_en,
   input  logic [ihfp_pkg::THR_W-1:0]          csr_write_data
);
   import ihfp_pkg::*;

   // stage numbers, counted from the word register
   localparam int S_TH    = 3;
   localparam int S_X2    = 5;
   localparam int S_SIN   = S_X2 + SIN_TERMS * TERM_LAT;
   localparam int S_SV    = S_SIN + 2;
   localparam int S_COS   = S_X2 + COS_TERMS * TERM_LAT;
   localparam int S_CS    = S_COS + 1;
   localparam int S_WD    = 1 + SQ_CELLS + 1;
   localparam int S_XY    = S_WD + 1 + DIV_CELLS + 1;
   localparam int S_PROD  = S_XY + 1;
   localparam int S_OUT   = S_PROD + 1;

   localparam int TH_DLY   = S_SIN - S_TH;
   localparam int SV_DLY   = S_COS - S_SV;
   localparam int QS_DLY   = S_COS - 1;
   localparam int MAG_DLY  = S_WD - 1;
   localparam int W_DLY    = S_XY - S_WD;
   localparam int SG_DLY   = S_XY - 2;
   localparam int CS_DLY   = S_XY - S_CS;
   localparam int POLE_DLY = S_PROD - 2;

   localparam int W_W   = FRAC_BITS + 1;
   localparam int MUL_W = 2 * IO_W;
   localparam int SUM_W = MUL_W + 1;
   localparam int SHR   = Q_W - FRAC_BITS;

   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;

   localparam logic signed [IO_W-1:0] ONE_S = IO_W'(ONE);

   typedef logic signed [IO_W-1:0] coord_type;

   // round a Q(2F) value to QF, ties away from zero, and saturate to one
   function automatic coord_type round_sat(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-1:0] mag;
      logic [SUM_W-1:0] rnd;
      mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
      rnd = (mag + (SUM_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (rnd > SUM_W'(ONE)) begin
         rnd = SUM_W'(ONE);
      end
      return v[SUM_W-1] ? -IO_W'(rnd) : IO_W'(rnd);
   endfunction

   // ------------------------------------------------------------------
   // control registers
   logic                busy_ff;
   logic [THR_W-1:0]    thr_ff;
   logic [S_OUT-1:0]    vld_ff;

   // hold the threshold and shift the valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         thr_ff  <= '0;
         vld_ff  <= '0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_write_en) begin
            thr_ff <= csr_write_data;
         end
         vld_ff <= {vld_ff[S_OUT-2:0], start & ~busy_ff};
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = vld_ff[S_OUT-1];

   // ------------------------------------------------------------------
   // stage 1: clamp, pole test, root operands, octant reduction
   coord_type             zc;
   logic [IO_W-1:0]       gap, zsum;
   logic [PHASE_BITS-1:0] ph;
   logic [Q_W-1:0]        r_raw;
   logic [TRIG_W-1:0]     r_fold;
   logic                  swap_in;
   logic [Q_W-1:0]        r_in;

   logic [SQ_IN_W-1:0]    nw_ff, nd_ff;
   logic                  pole_ff;
   logic [IO_W-1:0]       magx_ff, magy_ff;
   logic                  negx_ff, negy_ff;
   logic [Q_W-1:0]        r_ff;
   logic [1:0]            quad_ff;
   logic                  swap_ff;

   always_comb begin
      if (req_sphere_z > ONE_S) begin
         zc = ONE_S;
      end else if (req_sphere_z < -ONE_S) begin
         zc = -ONE_S;
      end else begin
         zc = req_sphere_z;
      end
      gap     = IO_W'(ONE_S - zc);
      zsum    = IO_W'(ONE_S + zc);
      ph      = req_fiber_phase[PHASE_BITS-1:0];
      r_raw   = {ph[PHASE_BITS-3:0], {(32 - PHASE_BITS){1'b0}}};
      swap_in = TRIG_W'(r_raw) > Q30_HALF;
      r_fold  = Q30_ONE - TRIG_W'(r_raw);
      r_in    = swap_in ? r_fold[Q_W-1:0] : r_raw;
   end

   always_ff @(posedge clock) begin
      nw_ff   <= SQ_IN_W'(zsum) << (FRAC_BITS + 1);
      nd_ff   <= SQ_IN_W'(gap) << (FRAC_BITS + 3);
      pole_ff <= gap <= IO_W'(thr_ff);
      magx_ff <= req_sphere_x[IO_W-1] ? IO_W'(-req_sphere_x) : IO_W'(req_sphere_x);
      magy_ff <= req_sphere_y[IO_W-1] ? IO_W'(-req_sphere_y) : IO_W'(req_sphere_y);
      negx_ff <= req_sphere_x[IO_W-1];
      negy_ff <= req_sphere_y[IO_W-1];
      r_ff    <= r_in;
      quad_ff <= ph[PHASE_BITS-1 -: 2];
      swap_ff <= swap_in;
   end

   // ------------------------------------------------------------------
   // angle and its square in Q30
   localparam int THP_W = Q_W + TRIG_W;
   localparam int X2P_W = 2 * Q_W;

   logic [THP_W-1:0] thp_ff;
   logic [Q_W-1:0]   th_ff;
   logic [X2P_W-1:0] x2p_ff;
   logic [Q_W-1:0]   x2_ff;

   always_ff @(posedge clock) begin
      thp_ff <= THP_W'(r_ff) * THP_W'(HALF_PI_Q30);
      th_ff  <= Q_W'((thp_ff + THP_W'(Q30_HALF)) >> Q_W);
      x2p_ff <= X2P_W'(th_ff) * X2P_W'(th_ff);
      x2_ff  <= Q_W'((x2p_ff + X2P_W'(Q30_HALF)) >> Q_W);
   end

   // ------------------------------------------------------------------
   // series cells for sine and cosine
   logic [Q_W-1:0]    sin_x2 [SIN_TERMS+1];
   logic [TRIG_W-1:0] sin_t  [SIN_TERMS+1];
   logic [Q_W-1:0]    cos_x2 [COS_TERMS+1];
   logic [TRIG_W-1:0] cos_t  [COS_TERMS+1];

   assign sin_x2[0] = x2_ff;
   assign sin_t[0]  = Q30_ONE;
   assign cos_x2[0] = x2_ff;
   assign cos_t[0]  = Q30_ONE;

   for (genvar i = 0; i < SIN_TERMS; i++) begin : g_sin
      ihfp_term_cell u_cell (
         .clock   (clock),
         .x2_i    (sin_x2[i]),
         .t_i     (sin_t[i]),
         .div_k_i (SIN_DIVS[i]),
         .recip_i (SIN_RECIP[i]),
         .x2_o    (sin_x2[i+1]),
         .t_o     (sin_t[i+1])
      );
   end

   for (genvar i = 0; i < COS_TERMS; i++) begin : g_cos
      ihfp_term_cell u_cell (
         .clock   (clock),
         .x2_i    (cos_x2[i]),
         .t_i     (cos_t[i]),
         .div_k_i (COS_DIVS[i]),
         .recip_i (COS_RECIP[i]),
         .x2_o    (cos_x2[i+1]),
         .t_o     (cos_t[i+1])
      );
   end

   // delay the angle to meet the last sine term
   logic [Q_W-1:0] th_dly_ff [TH_DLY];
   always_ff @(posedge clock) begin
      th_dly_ff[0] <= th_ff;
      for (int i = 1; i < TH_DLY; i++) begin
         th_dly_ff[i] <= th_dly_ff[i-1];
      end
   end

   // sine = angle times series, then align with cosine
   logic [THP_W-1:0]  svp_ff;
   logic [TRIG_W-1:0] sv_ff;
   logic [TRIG_W-1:0] sv_dly_ff [SV_DLY];
   always_ff @(posedge clock) begin
      svp_ff <= THP_W'(th_dly_ff[TH_DLY-1]) * THP_W'(sin_t[SIN_TERMS]);
      sv_ff  <= TRIG_W'((svp_ff + THP_W'(Q30_HALF)) >> Q_W);
      sv_dly_ff[0] <= sv_ff;
      for (int i = 1; i < SV_DLY; i++) begin
         sv_dly_ff[i] <= sv_dly_ff[i-1];
      end
   end

   // carry quadrant and swap along the series
   logic [1:0] quad_dly_ff [QS_DLY];
   logic       swap_dly_ff [QS_DLY];
   always_ff @(posedge clock) begin
      quad_dly_ff[0] <= quad_ff;
      swap_dly_ff[0] <= swap_ff;
      for (int i = 1; i < QS_DLY; i++) begin
         quad_dly_ff[i] <= quad_dly_ff[i-1];
         swap_dly_ff[i] <= swap_dly_ff[i-1];
      end
   end

   // undo the octant fold, round to QF and apply the quadrant
   logic [TRIG_W-1:0] cv_sel, sv_sel;
   logic [W_W-1:0]    cq, sq;
   coord_type         c_in, s_in, c_ff, s_ff;

   always_comb begin
      cv_sel = swap_dly_ff[QS_DLY-1] ? sv_dly_ff[SV_DLY-1] : cos_t[COS_TERMS];
      sv_sel = swap_dly_ff[QS_DLY-1] ? cos_t[COS_TERMS] : sv_dly_ff[SV_DLY-1];
      cq     = W_W'((cv_sel + (TRIG_W'(1) << (SHR - 1))) >> SHR);
      sq     = W_W'((sv_sel + (TRIG_W'(1) << (SHR - 1))) >> SHR);
      case (quad_dly_ff[QS_DLY-1])
         QUAD_FIRST: begin
            c_in = IO_W'(cq);
            s_in = IO_W'(sq);
         end
         QUAD_SECOND: begin
            c_in = -IO_W'(sq);
            s_in = IO_W'(cq);
         end
         QUAD_THIRD: begin
            c_in = -IO_W'(cq);
            s_in = -IO_W'(sq);
         end
         default: begin
            c_in = IO_W'(sq);
            s_in = -IO_W'(cq);
         end
      endcase
   end

   coord_type c_dly_ff [CS_DLY];
   coord_type s_dly_ff [CS_DLY];
   always_ff @(posedge clock) begin
      c_ff <= c_in;
      s_ff <= s_in;
      c_dly_ff[0] <= c_ff;
      s_dly_ff[0] <= s_ff;
      for (int i = 1; i < CS_DLY; i++) begin
         c_dly_ff[i] <= c_dly_ff[i-1];
         s_dly_ff[i] <= s_dly_ff[i-1];
      end
   end

   // ------------------------------------------------------------------
   // square root cells for w and d
   logic [SQ_IN_W-1:0]  w_rad  [SQ_CELLS+1];
   logic [SQ_ACC_W-1:0] w_root [SQ_CELLS+1];
   logic [SQ_IN_W-1:0]  d_rad  [SQ_CELLS+1];
   logic [SQ_ACC_W-1:0] d_root [SQ_CELLS+1];

   assign w_rad[0]  = nw_ff;
   assign w_root[0] = '0;
   assign d_rad[0]  = nd_ff;
   assign d_root[0] = '0;

   for (genvar j = 0; j < SQ_CELLS; j++) begin : g_sqrt
      localparam logic [SQ_ACC_W-1:0] BIT_J = SQ_ACC_W'(1) << (2 * (SQ_CELLS - 1 - j));
      ihfp_sqrt_cell u_w (
         .clock  (clock),
         .rad_i  (w_rad[j]),
         .root_i (w_root[j]),
         .bit_i  (BIT_J),
         .rad_o  (w_rad[j+1]),
         .root_o (w_root[j+1])
      );
      ihfp_sqrt_cell u_d (
         .clock  (clock),
         .rad_i  (d_rad[j]),
         .root_i (d_root[j]),
         .bit_i  (BIT_J),
         .rad_o  (d_rad[j+1]),
         .root_o (d_root[j+1])
      );
   end

   // carry magnitudes until the divisor is ready
   logic [IO_W-1:0] magx_dly_ff [MAG_DLY];
   logic [IO_W-1:0] magy_dly_ff [MAG_DLY];
   always_ff @(posedge clock) begin
      magx_dly_ff[0] <= magx_ff;
      magy_dly_ff[0] <= magy_ff;
      for (int i = 1; i < MAG_DLY; i++) begin
         magx_dly_ff[i] <= magx_dly_ff[i-1];
         magy_dly_ff[i] <= magy_dly_ff[i-1];
      end
   end

   // round the roots; never divide by zero
   logic [ROOT_W:0]  rw_inc, rd_inc;
   logic [DEN_W-1:0] d_in;
   logic [W_W-1:0]   w_ff;
   logic [DEN_W-1:0] d_ff, d2_ff;
   logic [DIV_W-1:0] dx_ff, dy_ff;

   always_comb begin
      rw_inc = {1'b0, w_root[SQ_CELLS][ROOT_W-1:0]} + (ROOT_W + 1)'(1);
      rd_inc = {1'b0, d_root[SQ_CELLS][ROOT_W-1:0]} + (ROOT_W + 1)'(1);
      d_in   = DEN_W'(rd_inc >> 1);
      if (d_in == '0) begin
         d_in = DEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      w_ff  <= W_W'(rw_inc >> 1);
      d_ff  <= d_in;
      dx_ff <= (DIV_W'(magx_dly_ff[MAG_DLY-1]) << FRAC_BITS) + DIV_W'(d_ff >> 1);
      dy_ff <= (DIV_W'(magy_dly_ff[MAG_DLY-1]) << FRAC_BITS) + DIV_W'(d_ff >> 1);
      d2_ff <= d_ff;
   end

   // ------------------------------------------------------------------
   // divider cells for x/d and y/d
   logic [DIV_W-1:0] x_rem [DIV_CELLS+1];
   logic [DEN_W-1:0] x_den [DIV_CELLS+1];
   logic [QUO_W-1:0] x_quo [DIV_CELLS+1];
   logic [DIV_W-1:0] y_rem [DIV_CELLS+1];
   logic [DEN_W-1:0] y_den [DIV_CELLS+1];
   logic [QUO_W-1:0] y_quo [DIV_CELLS+1];

   assign x_rem[0] = dx_ff;
   assign x_den[0] = d2_ff;
   assign x_quo[0] = '0;
   assign y_rem[0] = dy_ff;
   assign y_den[0] = d2_ff;
   assign y_quo[0] = '0;

   for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
      localparam logic [DIV_SH_W-1:0] SH_J = DIV_SH_W'(DIV_CELLS - 1 - j);
      ihfp_div_cell u_x (
         .clock   (clock),
         .rem_i   (x_rem[j]),
         .den_i   (x_den[j]),
         .quo_i   (x_quo[j]),
         .shift_i (SH_J),
         .rem_o   (x_rem[j+1]),
         .den_o   (x_den[j+1]),
         .quo_o   (x_quo[j+1])
      );
      ihfp_div_cell u_y (
         .clock   (clock),
         .rem_i   (y_rem[j]),
         .den_i   (y_den[j]),
         .quo_i   (y_quo[j]),
         .shift_i (SH_J),
         .rem_o   (y_rem[j+1]),
         .den_o   (y_den[j+1]),
         .quo_o   (y_quo[j+1])
      );
   end

   // carry signs, w and the pole flag to the rotation
   logic           negx_dly_ff [SG_DLY];
   logic           negy_dly_ff [SG_DLY];
   logic [W_W-1:0] w_dly_ff    [W_DLY];
   logic           pole_dly_ff [POLE_DLY];
   always_ff @(posedge clock) begin
      negx_dly_ff[0] <= negx_ff;
      negy_dly_ff[0] <= negy_ff;
      for (int i = 1; i < SG_DLY; i++) begin
         negx_dly_ff[i] <= negx_dly_ff[i-1];
         negy_dly_ff[i] <= negy_dly_ff[i-1];
      end
      w_dly_ff[0] <= w_ff;
      for (int i = 1; i < W_DLY; i++) begin
         w_dly_ff[i] <= w_dly_ff[i-1];
      end
      pole_dly_ff[0] <= pole_ff;
      for (int i = 1; i < POLE_DLY; i++) begin
         pole_dly_ff[i] <= pole_dly_ff[i-1];
      end
   end

   // saturate the quotients to one and restore the sign
   logic [QUO_W-1:0] qx_mag, qy_mag;
   coord_type        xb_ff, yb_ff;

   always_comb begin
      qx_mag = (x_quo[DIV_CELLS] > QUO_W'(ONE)) ? QUO_W'(ONE) : x_quo[DIV_CELLS];
      qy_mag = (y_quo[DIV_CELLS] > QUO_W'(ONE)) ? QUO_W'(ONE) : y_quo[DIV_CELLS];
   end

   always_ff @(posedge clock) begin
      xb_ff <= negx_dly_ff[SG_DLY-1] ? -IO_W'(qx_mag) : IO_W'(qx_mag);
      yb_ff <= negy_dly_ff[SG_DLY-1] ? -IO_W'(qy_mag) : IO_W'(qy_mag);
   end

   // ------------------------------------------------------------------
   // rotation by the phase: products, then sums and rounding
   coord_type c41, s41, w41;
   logic signed [MUL_W-1:0] cw_ff, sw_ff, cx_ff, sy_ff, sx_ff, cy_ff;
   logic                    pole42_ff;

   assign c41 = c_dly_ff[CS_DLY-1];
   assign s41 = s_dly_ff[CS_DLY-1];
   assign w41 = IO_W'(w_dly_ff[W_DLY-1]);

   always_ff @(posedge clock) begin
      cw_ff     <= c41 * w41;
      sw_ff     <= s41 * w41;
      cx_ff     <= c41 * xb_ff;
      sy_ff     <= s41 * yb_ff;
      sx_ff     <= s41 * xb_ff;
      cy_ff     <= c41 * yb_ff;
      pole42_ff <= pole_dly_ff[POLE_DLY-1];
   end

   logic signed [SUM_W-1:0] xsum, ysum;
   coord_type c42, s42;
   coord_type ow_ff, ox_ff, oy_ff, oz_ff;
   logic      pole_out_ff;

   // cos and sin again at this stage for the pole case
   coord_type c42_ff, s42_ff;
   always_ff @(posedge clock) begin
      c42_ff <= c41;
      s42_ff <= s41;
   end
   assign c42 = c42_ff;
   assign s42 = s42_ff;

   always_comb begin
      xsum = SUM_W'(cx_ff) - SUM_W'(sy_ff);
      ysum = SUM_W'(sx_ff) + SUM_W'(cy_ff);
   end

   // pick the pole answer or the rotated point
   always_ff @(posedge clock) begin
      pole_out_ff <= pole42_ff;
      if (pole42_ff) begin
         ow_ff <= c42;
         ox_ff <= s42;
         oy_ff <= '0;
         oz_ff <= '0;
      end else begin
         ow_ff <= round_sat(SUM_W'(cw_ff));
         ox_ff <= round_sat(xsum);
         oy_ff <= round_sat(ysum);
         oz_ff <= round_sat(SUM_W'(sw_ff));
      end
   end

   assign rsp_out_w   = ow_ff;
   assign rsp_out_x   = ox_ff;
   assign rsp_out_y   = oy_ff;
   assign rsp_out_z   = oz_ff;
   assign rsp_at_pole = pole_out_ff;

   // ------------------------------------------------------------------
   `IHFP_ASSERT_IMPL(a_pole_zero, clock, reset, rsp_strobe && rsp_at_pole, rsp_out_y == '0 && rsp_out_z == '0, "pole word carries non-zero y or z")
   `IHFP_ASSERT_IMPL(a_w_range, clock, reset, rsp_strobe, rsp_out_w <= ONE_S && rsp_out_w >= -ONE_S, "w out of range")
   `IHFP_ASSERT_IMPL(a_x_range, clock, reset, rsp_strobe, rsp_out_x <= ONE_S && rsp_out_x >= -ONE_S, "x out of range")
   `IHFP_ASSERT(a_busy_low, clock, reset, !$past(reset) |-> !busy, "busy high outside reset recovery")

endmodule
